@@ design/pt_tbl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pt_tbl_pkg : shared constants for the Pascal triangle table
// Field widths and the default triangle limit.
// ----------------------------------------------------------------------------
package pt_tbl_pkg;

  localparam int ROW_W         = 6;   // row, col and top_row fields
  localparam int VALUE_W       = 31;  // coefficient width
  localparam int TOP_ROW_LIMIT = 33;  // highest row that fits 31 bits
  localparam logic [ROW_W-1:0] TOP_ROW_RESET = ROW_W'(33);

endpackage

@@ design/pascal_triangle_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pascal_triangle_table : binomial coefficient lookup table
// Builds rows of Pascal's triangle in a packed RAM and serves C(row, col).
// ----------------------------------------------------------------------------
// Usage: a request is taken on a rising edge with start high and busy low.
// Its result goes through the registered RAM read and result register and
// shows on value/in_range for exactly one cycle, marked by done; there is
// no way to hold a result off, so the receiver must take it then. Once the
// triangle is built and cfg_we is low, the block takes one request per
// clock and keeps two in flight. Rows are built on demand: while a request
// waits and top_row (clamped to the limit) names rows not yet built, busy
// stays high and the missing rows are built first. Row n has n+1 entries,
// so the first request after reset with top_row at its reset value waits
// for all (L+1)(L+2)/2 entries (595 for L = 33) to be written. If start
// drops mid-build the build pauses and picks up again with the next
// request. The single RAM write port sets the build rate (one entry a cycle).
// Rows are never removed: lowering top_row keeps serving the rows built.
// A top_row above the limit is treated as the limit. A request for a row
// not yet built, or with col > row, returns value 0 and in_range 0.
// busy also follows cfg_we so that a request in the same cycle as a write
// sees the new top_row.
// ----------------------------------------------------------------------------
module pascal_triangle_table #(
  parameter int TopRowLimit = pt_tbl_pkg::TOP_ROW_LIMIT
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [pt_tbl_pkg::ROW_W-1:0]      cfg_wdata,
  // request
  input  logic                              start,
  output logic                              busy,
  input  logic [pt_tbl_pkg::ROW_W-1:0]      row,
  input  logic [pt_tbl_pkg::ROW_W-1:0]      col,
  // result
  output logic                              done,
  output logic [pt_tbl_pkg::VALUE_W-1:0]    value,
  output logic                              in_range
);
  import pt_tbl_pkg::*;

  // Packed storage: row n starts at n(n+1)/2.
  localparam int Depth  = (TopRowLimit + 1) * (TopRowLimit + 2) / 2;
  localparam int IdxW   = $clog2(Depth);
  localparam int BaseW  = $clog2(Depth + 1);     // holds base of row L+1
  localparam logic [ROW_W-1:0] Limit = ROW_W'(TopRowLimit);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] top_row;
  logic [ROW_W-1:0] goal;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_row <= TOP_ROW_RESET;
    end else if (cfg_we) begin
      top_row <= cfg_wdata;
    end
  end

  assign goal = (top_row > Limit) ? Limit : top_row;

  // --------------------------------------------------------------------------
  // Build sequencer: issue stage walks k = 0..n of row rows_built, reading
  // the row above; write stage adds the read entry to the one held from the
  // previous entry of the row and writes the new entry.
  // Issue only runs while a request waits, so rows follow top_row as seen
  // by requests, not by writes alone.
  // rows_built counts rows issued; it equals rows written whenever idle.
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0]   rows_built;
  logic [ROW_W-1:0]   issue_k;
  logic [BaseW-1:0]   cur_base;
  logic               issuing;
  logic               row_last;
  logic [BaseW-1:0]   up_addr;
  logic [BaseW-1:0]   cur_addr;

  assign issuing  = start && (rows_built <= goal);
  assign row_last = (issue_k == rows_built);
  assign up_addr  = cur_base - BaseW'(rows_built) + BaseW'(issue_k);
  assign cur_addr = cur_base + BaseW'(issue_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_built <= '0;
      issue_k    <= '0;
      cur_base   <= '0;
    end else if (issuing) begin
      if (row_last) begin
        issue_k    <= '0;
        rows_built <= rows_built + ROW_W'(1);
        cur_base   <= cur_base + BaseW'(rows_built) + BaseW'(1);
      end else begin
        issue_k    <= issue_k + ROW_W'(1);
      end
    end
  end

  // write stage
  logic               s1_valid;
  logic [ROW_W-1:0]   s1_k;
  logic [ROW_W-1:0]   s1_n;
  logic [IdxW-1:0]    s1_addr;
  logic [VALUE_W-1:0] hold;      // entry k-1 of the row above

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issuing;
    end
  end

  always_ff @(posedge clk) begin
    s1_k    <= issue_k;
    s1_n    <= rows_built;
    s1_addr <= cur_addr[IdxW-1:0];
  end

  // --------------------------------------------------------------------------
  // Lookup pipeline: address, then registered RAM data, then result reg.
  // --------------------------------------------------------------------------
  logic                 accept;
  logic [2*ROW_W:0]     row_prod;
  logic [2*ROW_W:0]     lk_addr_full;
  logic                 lk_hit_d;
  logic                 lk_valid;
  logic                 lk_hit;

  assign accept       = start && !busy;
  assign row_prod     = (2*ROW_W+1)'(row) * (2*ROW_W+1)'(row + ROW_W'(1));
  assign lk_addr_full = (row_prod >> 1) + (2*ROW_W+1)'(col);
  assign lk_hit_d     = (row < rows_built) && (col <= row);

  // --------------------------------------------------------------------------
  // RAM: one write port, one read port (registered), with forwarding when
  // the read hits the entry written in the same cycle.
  // --------------------------------------------------------------------------
  logic [VALUE_W-1:0] mem [Depth];
  logic [IdxW-1:0]    raddr;
  logic [VALUE_W-1:0] mem_rd;
  logic [VALUE_W-1:0] fwd_data;
  logic               fwd;
  logic [VALUE_W-1:0] rd_q;
  logic               wen;
  logic [VALUE_W-1:0] wdata;

  assign raddr = issuing ? up_addr[IdxW-1:0] : lk_addr_full[IdxW-1:0];
  assign wen   = s1_valid;
  assign wdata = ((s1_k == '0) || (s1_k == s1_n)) ? VALUE_W'(1) : (rd_q + hold);
  assign rd_q  = fwd ? fwd_data : mem_rd;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[s1_addr] <= wdata;
    end
    mem_rd   <= mem[raddr];
    fwd_data <= wdata;
    if (s1_valid) begin
      hold <= rd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= wen && (s1_addr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lk_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      lk_valid <= accept;
      done     <= lk_valid;
    end
  end

  always_ff @(posedge clk) begin
    lk_hit   <= lk_hit_d;
    value    <= lk_hit ? rd_q : '0;
    in_range <= lk_hit;
  end

  assign busy = cfg_we || issuing || s1_valid;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_build_in_lookup: assert property (@(posedge clk) disable iff (rst)
    lk_valid |-> !s1_valid)
    else $error("build write overlaps a lookup read");

  a_zero_when_out: assert property (@(posedge clk) disable iff (rst)
    (done && !in_range) |-> (value == '0))
    else $error("out-of-range result carries a nonzero value");

  a_rows_bounded: assert property (@(posedge clk) disable iff (rst)
    rows_built <= Limit + ROW_W'(1))
    else $error("row count past the triangle limit");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("accepted request gave no result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(lk_valid))
    else $error("result without a request in flight");

endmodule

@@ dv/pt_coeff_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pt_coeff_check : coefficient checker for the Pascal triangle table
// Watches the config, request and result ports. It keeps its own copy of
// top_row and of the rows built, predicts each C(row, col) result, and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module pt_coeff_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pt_tbl_pkg::ROW_W-1:0]   cfg_wdata,
  input  logic                           start,
  input  logic                           busy,
  input  logic [pt_tbl_pkg::ROW_W-1:0]   row,
  input  logic [pt_tbl_pkg::ROW_W-1:0]   col,
  input  logic                           done,
  input  logic [pt_tbl_pkg::VALUE_W-1:0] value,
  input  logic                           in_range,
  output int                             fail_count,
  output int                             pending
);
  import pt_tbl_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               in_range;
  } coeff_t;

  // full triangle, rows 0..limit, built once by Pascal's rule
  logic [VALUE_W-1:0] pascal [0:TOP_ROW_LIMIT][0:TOP_ROW_LIMIT];

  coeff_t             coeff_due [$];
  int                 rows_ready   = 0;
  logic [ROW_W-1:0]   top_row_copy = TOP_ROW_RESET;
  int                 errs         = 0;

  initial begin : fill_triangle
    for (int n = 0; n <= TOP_ROW_LIMIT; n++) begin
      for (int k = 0; k <= TOP_ROW_LIMIT; k++) begin
        if (k > n)
          pascal[n][k] = '0;
        else if (k == 0 || k == n)
          pascal[n][k] = VALUE_W'(1);
        else
          pascal[n][k] = pascal[n-1][k] + pascal[n-1][k-1];
      end
    end
  end

  function automatic coeff_t lookup_coeff(input logic [ROW_W-1:0] n, input logic [ROW_W-1:0] k);
    coeff_t c;
    if (int'(n) < rows_ready && k <= n) begin
      c.value    = pascal[n][k];
      c.in_range = 1'b1;
    end else begin
      c.value    = '0;
      c.in_range = 1'b0;
    end
    return c;
  endfunction

  always @(posedge clk) begin : watch
    coeff_t want;
    int     goal;
    if (rst) begin
      coeff_due.delete();
      rows_ready   = 0;
      top_row_copy = TOP_ROW_RESET;
    end else begin
      if (done) begin
        if (coeff_due.size() == 0) begin
          $error("result with no request waiting: value %0d in_range %0b", value, in_range);
          errs++;
        end else begin
          want = coeff_due.pop_front();
          if (value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value);
            errs++;
          end
          if (in_range !== want.in_range) begin
            $error("in_range: expected %0b, got %0b", want.in_range, in_range);
            errs++;
          end
        end
      end
      // a request in the same cycle as a write sees the new top_row
      if (cfg_we)
        top_row_copy = cfg_wdata;
      if (start && !busy) begin
        goal = (int'(top_row_copy) > TOP_ROW_LIMIT) ? TOP_ROW_LIMIT : int'(top_row_copy);
        if (rows_ready <= goal)
          rows_ready = goal + 1;
        coeff_due = {coeff_due, lookup_coeff(row, col)};
      end
    end
    pending    <= coeff_due.size();
    fail_count <= errs;
  end

endmodule

@@ dv/pascal_triangle_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pascal_triangle_table_tb : regression for the Pascal triangle table
// Steps top_row through a plan of settings (raised, lowered, above the
// limit), sends directed corner requests and biased random requests with
// varying sender gaps, and leaves prediction to pt_coeff_check.
// ----------------------------------------------------------------------------
module pascal_triangle_table_tb;
  import pt_tbl_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;  // far above the slowest clean run
  localparam int SETTLE_CYCLES    = 6;       // two-stage pipeline plus margin
  localparam int RANDOM_PER_PHASE = 200;
  localparam int N_PHASES         = 7;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [ROW_W-1:0]   cfg_wdata = '0;
  logic               start     = 1'b0;
  logic [ROW_W-1:0]   row       = '0;
  logic [ROW_W-1:0]   col       = '0;
  logic               busy;
  logic               done;
  logic [VALUE_W-1:0] value;
  logic               in_range;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int n_sent      = 0;
  int idle_pct    = 0;

  // top_row plan: small first, then raised, lowered to the bottom extreme,
  // raised again, all ones (clamped to the limit), the limit itself, and
  // above the limit once every row is built
  logic [ROW_W-1:0] top_row_plan [0:N_PHASES-1] =
    '{6'd2, 6'd9, 6'd0, 6'd19, 6'd63, 6'd33, 6'd40};

  pascal_triangle_table u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .start    (start),
    .busy     (busy),
    .row      (row),
    .col      (col),
    .done     (done),
    .value    (value),
    .in_range (in_range)
  );

  pt_coeff_check u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .row       (row),
    .col       (col),
    .done      (done),
    .value     (value),
    .in_range  (in_range),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One request. start stays high into the next request unless a gap is
  // drawn, so start never takes two assignments in one step.
  task automatic lookup(input logic [ROW_W-1:0] r, input logic [ROW_W-1:0] c);
    start <= 1'b1;
    row   <= r;
    col   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);  // held until the block takes it
    n_sent++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding request to come back,
  // then wait out the SETTLE_CYCLES margin as well.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen with the block drained.
  task automatic write_top_row(input logic [ROW_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly requests inside the built triangle; some with col past row;
  // the rest fully random over both 6-bit fields.
  task automatic random_lookup(input int hi);
    int               pick;
    logic [ROW_W-1:0] r;
    logic [ROW_W-1:0] c;
    pick = $urandom_range(99);
    if (pick < 60) begin
      r = ROW_W'($urandom_range(hi));
      c = ROW_W'($urandom_range(int'(r)));
    end else if (pick < 75) begin
      r = ROW_W'($urandom_range(hi));
      c = ROW_W'($urandom_range(63, int'(r) + 1));
    end else begin
      r = ROW_W'($urandom);
      c = ROW_W'($urandom);
    end
    lookup(r, c);
  endtask

  initial begin : stimulus
    int hint;  // highest row the plan has asked for so far
    int goal;
    hint = 0;

    repeat (12) @(posedge clk);
    // First top_row write lands on the first cycle out of reset, before any
    // request has asked for rows to be built.
    rst       <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_wdata <= top_row_plan[0];
    @(posedge clk);
    cfg_we    <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0)
        write_top_row(top_row_plan[p]);
      goal = (int'(top_row_plan[p]) > TOP_ROW_LIMIT) ? TOP_ROW_LIMIT
                                                     : int'(top_row_plan[p]);
      if (goal > hint)
        hint = goal;
      // sender gaps: 10 % for the first phases, 50 % next, none at the end
      idle_pct = (p < 3) ? 10 : (p < 5) ? 50 : 0;

      case (p)
        0: begin
          // small triangle: edges, inner entry, col past row, unbuilt rows
          lookup(6'd0, 6'd0);
          lookup(6'd2, 6'd1);
          lookup(6'd2, 6'd2);
          lookup(6'd2, 6'd3);
          lookup(6'd3, 6'd0);
          lookup(6'd63, 6'd63);
          lookup(6'd0, 6'd63);
        end
        2: begin
          // top_row lowered to 0: rows up to 9 must still be served
          lookup(6'd9, 6'd4);
          lookup(6'd9, 6'd9);
          lookup(6'd9, 6'd10);
          lookup(6'd10, 6'd0);
        end
        4: begin
          // all ones clamped to the limit: full triangle and its borders
          lookup(6'd33, 6'd0);
          lookup(6'd33, 6'd16);
          lookup(6'd33, 6'd17);
          lookup(6'd33, 6'd33);
          lookup(6'd33, 6'd34);
          lookup(6'd34, 6'd0);
          lookup(6'd63, 6'd0);
          lookup(6'd32, 6'd33);
          lookup(6'd31, 6'd15);
          lookup(6'd21, 6'd42);
        end
        default: ;
      endcase

      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        // mid-phase hold-off until every request has come back
        if (i == RANDOM_PER_PHASE / 2)
          settle();
        random_lookup(hint);
      end
    end

    settle();
    $display("Covered %0d lookups over %0d top_row settings (2, 9, 0, 19, 63, 33, 40)",
             n_sent, N_PHASES);
    $display("Sender gaps at 10%%, 50%% and none, with drains mid-phase and before writes");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/pt_tbl_pkg.sv
design/pascal_triangle_table.sv
dv/pt_coeff_check.sv
dv/pascal_triangle_table_tb.sv
